// ===== rtl/lpli_pkg.sv =====
// Package for the piecewise linear interpolator: table sizes, codes and types.
// Used by lpli_div and lut_piecewise_linear_interpolator; depends on nothing.
package lpli_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int FLOW_W     = 16;
  localparam int DUTY_W     = 16;
  localparam int ENTRY_W    = FLOW_W + DUTY_W;
  localparam int INDEX_W    = 6;
  localparam int COUNT_W    = 7;

  localparam int PROD_W     = FLOW_W + DUTY_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING = 2'd2;

  localparam logic [DUTY_W-1:0] DUTY_CEILING_RST = 16'hFFFF;

  typedef enum logic [2:0] {
    OUT_WRITTEN = 3'd0,
    OUT_EMPTY   = 3'd1,
    OUT_BELOW   = 3'd2,
    OUT_ABOVE   = 3'd3,
    OUT_INTERP  = 3'd4,
    OUT_NOSEG   = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SCAN,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                done;
    logic                rem_nz;
    logic [DUTY_W-1:0]   quot;
  } div_res_t;

endpackage

// ===== rtl/lpli_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module lpli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lpli_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle, for the interpolation step.
// Depends on lpli_pkg for widths and the result struct.
module lpli_div
  import lpli_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [FLOW_W-1:0] divisor,
  output div_res_t          res
);

  logic [PROD_W-1:0]    dvd_r;
  logic [FLOW_W-1:0]    rem_r;
  logic [FLOW_W-1:0]    dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [FLOW_W:0]      shifted;
  logic [FLOW_W:0]      diff;
  logic                 ge;

  assign shifted = {rem_r, dvd_r[PROD_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign ge      = shifted >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[PROD_W-2:0], ge};
      rem_r <= ge ? diff[FLOW_W-1:0] : shifted[FLOW_W-1:0];
    end
  end

  assign res.done   = done_r;
  assign res.rem_nz = |rem_r;
  assign res.quot   = dvd_r[DUTY_W-1:0];

endmodule

// ===== rtl/lut_piecewise_linear_interpolator.sv =====
// Top level of the flow-to-duty piecewise linear lookup table.
// Depends on lpli_pkg, lpli_ram and lpli_div.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_stall    kind, point_index, point_duty,
//                                              point_flow, query_flow
//   out_     output     out_valid / out_stall  duty_out, outcome
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A write item goes straight to the done state. A query that clamps checks the
// first and then the last table point; one that interpolates over n points does
// one table read per segment, then a multiply and a bit-serial divide.
// Synchronous active-low reset clears control and the configuration registers.
// One item is in work at a time; the next transfer is taken while a finished
// result still waits in the output register under out_stall.
module lut_piecewise_linear_interpolator
  import lpli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [INDEX_W-1:0]    in_point_index,
  input  logic [DUTY_W-1:0]     in_point_duty,
  input  logic [FLOW_W-1:0]     in_point_flow,
  input  logic [FLOW_W-1:0]     in_query_flow,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DUTY_W-1:0]     out_duty_out,
  output logic [2:0]            out_outcome,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0] point_count_r;
  logic [DUTY_W-1:0]  duty_floor_r;
  logic [DUTY_W-1:0]  duty_ceiling_r;

  logic [FLOW_W-1:0]  q_r;
  logic [CNT_W-1:0]   n_r;
  logic [CNT_W-1:0]   idx_r;
  logic [FLOW_W-1:0]  pf_r;
  logic [DUTY_W-1:0]  pd_r;
  logic [FLOW_W-1:0]  a_r;
  logic [DUTY_W-1:0]  b_r;
  logic [FLOW_W-1:0]  den_r;
  logic               neg_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DUTY_W-1:0]  res_duty_r;
  outcome_t           res_outcome_r;

  logic               out_valid_r;
  logic [DUTY_W-1:0]  out_duty_r;
  outcome_t           out_outcome_r;

  logic               in_xfer;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CNT_W-1:0]   rd_cnt;
  logic [ENTRY_W-1:0] rd_data;
  logic [FLOW_W-1:0]  rd_flow;
  logic [DUTY_W-1:0]  rd_duty;
  logic [CNT_W-1:0]   n_sat;
  logic [CNT_W-1:0]   idx_inc;
  logic               hit;
  logic               more;
  logic               out_free;
  logic               ld_out;
  logic               div_start;
  div_res_t           div_res;

  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign rd_flow   = rd_data[FLOW_W-1:0];
  assign rd_duty   = rd_data[ENTRY_W-1:FLOW_W];
  assign n_sat     = (32'(point_count_r) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                             : CNT_W'(point_count_r);
  assign idx_inc   = idx_r + CNT_W'(1);
  assign hit       = (q_r >= pf_r) && (q_r <= rd_flow);
  assign more      = idx_inc < n_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign wr_en     = in_xfer && (in_kind == KIND_WRITE)
                     && (32'(in_point_index) < 32'(MAX_POINTS));
  assign wr_addr   = ADDR_W'(in_point_index);

  lpli_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({in_point_duty, in_point_flow}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lpli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (den_r),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r  <= '0;
      duty_floor_r   <= '0;
      duty_ceiling_r <= DUTY_CEILING_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POINT_COUNT:  point_count_r  <= cfg_data[COUNT_W-1:0];
        CFG_DUTY_FLOOR:   duty_floor_r   <= cfg_data[DUTY_W-1:0];
        CFG_DUTY_CEILING: duty_ceiling_r <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_kind == KIND_WRITE || n_sat == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHK_FIRST;
          end
        end
      end
      ST_CHK_FIRST: state_nxt = (q_r <= rd_flow) ? ST_DONE : ST_CHK_LAST;
      ST_CHK_LAST:  state_nxt = (q_r >= rd_flow) ? ST_DONE : ST_SCAN;
      ST_SCAN: begin
        if (hit) begin
          state_nxt = (rd_flow == pf_r) ? ST_DONE : ST_MUL;
        end else if (!more) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL:      state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: state_nxt = div_res.done ? ST_DONE : ST_DIV_WAIT;
      ST_DONE:     state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    ld_out    = 1'b0;
    rd_cnt    = '0;
    unique case (state_r)
      ST_IDLE:      in_stall  = 1'b0;
      ST_CHK_FIRST: rd_cnt    = n_r - CNT_W'(1);
      ST_CHK_LAST:  rd_cnt    = CNT_W'(1);
      ST_SCAN:      rd_cnt    = idx_inc;
      ST_DIV_GO:    div_start = 1'b1;
      ST_DONE:      ld_out    = out_free;
      default: ;
    endcase
  end

  assign rd_addr = rd_cnt[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          q_r <= in_query_flow;
          n_r <= n_sat;
          if (in_kind == KIND_WRITE) begin
            res_duty_r    <= '0;
            res_outcome_r <= OUT_WRITTEN;
          end else begin
            res_duty_r    <= duty_floor_r;
            res_outcome_r <= OUT_EMPTY;
          end
        end
      end
      ST_CHK_FIRST: begin
        pf_r          <= rd_flow;
        pd_r          <= rd_duty;
        res_duty_r    <= rd_duty;
        res_outcome_r <= OUT_BELOW;
      end
      ST_CHK_LAST: begin
        idx_r         <= CNT_W'(1);
        res_duty_r    <= rd_duty;
        res_outcome_r <= OUT_ABOVE;
      end
      ST_SCAN: begin
        if (hit) begin
          res_duty_r    <= pd_r;
          res_outcome_r <= OUT_INTERP;
          a_r           <= q_r - pf_r;
          den_r         <= rd_flow - pf_r;
          neg_r         <= rd_duty < pd_r;
          b_r           <= (rd_duty < pd_r) ? (pd_r - rd_duty) : (rd_duty - pd_r);
        end else if (more) begin
          pf_r  <= rd_flow;
          pd_r  <= rd_duty;
          idx_r <= idx_inc;
        end else begin
          res_duty_r    <= duty_ceiling_r;
          res_outcome_r <= OUT_NOSEG;
        end
      end
      ST_MUL: prod_r <= PROD_W'(a_r) * PROD_W'(b_r);
      ST_DIV_WAIT: begin
        if (div_res.done) begin
          if (neg_r) begin
            res_duty_r <= pd_r - div_res.quot - DUTY_W'(div_res.rem_nz);
          end else begin
            res_duty_r <= pd_r + div_res.quot;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_duty_r    <= res_duty_r;
      out_outcome_r <= res_outcome_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_duty_out = out_duty_r;
  assign out_outcome  = out_outcome_r;

endmodule
